// ===== src/fbpa_pkg.sv =====
// Shared types and constants of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int NUM_BLOCKS_DEF  = 32;
  localparam int BLOCK_BYTES_DEF = 64;

  localparam int ROW_W    = 32;
  localparam int ROW_BITS = 5;

  localparam logic [31:0] POOL_BASE_RST = 32'd4096;

  localparam logic REG_POOL_BASE = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef struct packed {
    logic    cap_in;
    logic    rd_alloc;
    logic    pick;
    logic    mul;
    logic    wr_alloc;
    logic    div_init;
    logic    div_step;
    logic    rd_free;
    logic    wr_free;
    logic    ld_out;
    status_t out_kind;
  } fbpa_cmd_t;

  typedef struct packed {
    logic in_op;
    logic any_free;
    logic free_ign;
    logic blk_used;
    logic out_free;
  } fbpa_sts_t;

endpackage

// ===== src/fbpa_ctrl.sv =====
// Control state machine of the fixed block pool allocator.
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbpa_pkg::fbpa_sts_t sts,
  output fbpa_pkg::fbpa_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_AFIND = 9'b000000010,
    S_APICK = 9'b000000100,
    S_AMUL  = 9'b000001000,
    S_AFIN  = 9'b000010000,
    S_FCHK  = 9'b000100000,
    S_FDIV  = 9'b001000000,
    S_FRD   = 9'b010000000,
    S_FUPD  = 9'b100000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = (sts.in_op == fbpa_pkg::OP_FREE) ? S_FCHK : S_AFIND;
        end
      end
      S_AFIND: begin
        if (sts.any_free) begin
          cmd.rd_alloc = 1'b1;
          state_nxt    = S_APICK;
        end else if (sts.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.out_kind = fbpa_pkg::ST_FULL;
          state_nxt    = S_IDLE;
        end
      end
      S_APICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_AFIN;
      end
      S_AFIN: begin
        if (sts.out_free) begin
          cmd.wr_alloc = 1'b1;
          cmd.ld_out   = 1'b1;
          cmd.out_kind = fbpa_pkg::ST_ALLOCATED;
          state_nxt    = S_IDLE;
        end
      end
      S_FCHK: begin
        if (!sts.free_ign) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_FDIV;
        end else if (sts.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.out_kind = fbpa_pkg::ST_IGNORED;
          state_nxt    = S_IDLE;
        end
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_FRD;
      end
      S_FRD: begin
        cmd.rd_free = 1'b1;
        state_nxt   = S_FUPD;
      end
      S_FUPD: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          if (sts.blk_used) begin
            cmd.wr_free  = 1'b1;
            cmd.out_kind = fbpa_pkg::ST_FREED;
          end else begin
            cmd.out_kind = fbpa_pkg::ST_IGNORED;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> sts.out_free)
    else $error("result loaded while the output register is occupied");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a transaction");
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");
`endif

endmodule

// ===== src/fbpa_dp.sv =====
// Datapath of the fixed block pool allocator: used map, block index unit, counters, result register.
`timescale 1ns / 1ps

module fbpa_dp #(
  parameter int NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fbpa_pkg::fbpa_cmd_t cmd,
  output fbpa_pkg::fbpa_sts_t sts,
  input  logic                in_opcode,
  input  logic [31:0]         in_free_address,
  input  logic [31:0]         pool_base,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [31:0]         out_block_address,
  output logic [4:0]          out_block_index,
  output logic [5:0]          out_used_count,
  output logic [31:0]         out_alloc_total,
  output logic [31:0]         out_free_total
);

  localparam int ROW_W      = fbpa_pkg::ROW_W;
  localparam int ROW_BITS   = fbpa_pkg::ROW_BITS;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int NROW_USED  = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int RA_W       = (NROW_USED > 1) ? $clog2(NROW_USED) : 1;
  localparam int ROWS       = 2 ** RA_W;
  localparam int CI_W       = RA_W + ROW_BITS;
  localparam int UC_W       = $clog2(NUM_BLOCKS + 1);
  localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int OFF_W      = $clog2(POOL_BYTES);
  localparam int DIV_SH     = OFF_W + $clog2(BLOCK_BYTES);
  localparam int PROD_W     = 2 * OFF_W + 1;
  // Rounded-up reciprocal of the block size; exact for every offset below 2^OFF_W.
  localparam logic [OFF_W:0] DIV_MUL = (OFF_W + 1)'(
    ((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES));

  logic [31:0]       addr_r;
  logic [OFF_W-1:0]  rem_r;
  logic [IDX_W-1:0]  quot_r;
  logic [ROW_W-1:0]  mem_r [ROWS];
  logic [ROWS-1:0]   row_vld_r;
  logic [ROWS-1:0]   row_full_r;
  logic [ROW_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [RA_W-1:0]   rd_row_r;
  logic [CI_W-1:0]   idx_r;
  logic [ROW_W-1:0]  new_row_r;
  logic [31:0]       prod_r;
  logic [UC_W-1:0]   used_cnt_r;
  logic [31:0]       alloc_cnt_r;
  logic [31:0]       free_cnt_r;

  logic              out_valid_r;
  fbpa_pkg::status_t out_status_r;
  logic [31:0]       out_addr_r;
  logic [4:0]        out_index_r;
  logic [5:0]        out_used_r;
  logic [31:0]       out_alloc_r;
  logic [31:0]       out_free_r;

  logic [31:0]       offset;
  logic [PROD_W-1:0] div_prod;
  logic [RA_W-1:0]   free_row_enc;
  logic              any_free;
  logic [ROW_W-1:0]  pad;
  logic [ROW_W-1:0]  row_val;
  logic [ROW_BITS-1:0] pick_bit;
  logic [CI_W-1:0]   ci_f;
  logic [RA_W-1:0]   frow;
  logic [ROW_BITS-1:0] fbit;
  logic [RA_W-1:0]   rd_row;
  logic [RA_W-1:0]   wr_row;
  logic [ROW_W-1:0]  wr_data;
  logic              mem_we;
  logic              mem_re;
  logic [UC_W-1:0]   used_nxt;
  logic [31:0]       alloc_nxt;
  logic [31:0]       free_nxt;
  logic [31:0]       res_addr;
  logic [4:0]        res_index;

  assign offset   = addr_r - pool_base;
  assign div_prod = PROD_W'(rem_r) * PROD_W'(DIV_MUL);

  always_comb begin
    free_row_enc = '0;
    any_free     = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_r[r]) begin
        free_row_enc = RA_W'(r);
        any_free     = 1'b1;
      end
    end
  end

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      pad[b] = (((32'(rd_row_r) << ROW_BITS) | 32'(b)) >= 32'(NUM_BLOCKS));
    end
  end

  assign row_val = rd_vld_r ? rd_data_r : pad;

  always_comb begin
    pick_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!row_val[b]) begin
        pick_bit = ROW_BITS'(b);
      end
    end
  end

  assign ci_f = CI_W'(quot_r);
  assign frow = ci_f[CI_W-1:ROW_BITS];
  assign fbit = ci_f[ROW_BITS-1:0];

  assign mem_re  = cmd.rd_alloc | cmd.rd_free;
  assign mem_we  = cmd.wr_alloc | cmd.wr_free;
  assign rd_row  = cmd.rd_alloc ? free_row_enc : frow;
  assign wr_row  = cmd.wr_alloc ? idx_r[CI_W-1:ROW_BITS] : frow;
  assign wr_data = cmd.wr_alloc ? new_row_r : (row_val & ~(ROW_W'(1) << fbit));

  always_comb begin
    used_nxt  = used_cnt_r;
    alloc_nxt = alloc_cnt_r;
    free_nxt  = free_cnt_r;
    if (cmd.wr_alloc) begin
      used_nxt  = used_cnt_r + UC_W'(1);
      alloc_nxt = alloc_cnt_r + 32'd1;
    end else if (cmd.wr_free) begin
      used_nxt = used_cnt_r - UC_W'(1);
      free_nxt = free_cnt_r + 32'd1;
    end
  end

  always_comb begin
    case (cmd.out_kind)
      fbpa_pkg::ST_ALLOCATED: begin
        res_addr  = pool_base + prod_r;
        res_index = 5'(idx_r);
      end
      fbpa_pkg::ST_FREED: begin
        res_addr  = '0;
        res_index = 5'(ci_f);
      end
      default: begin
        res_addr  = '0;
        res_index = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[wr_row] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      addr_r <= in_free_address;
    end
    if (cmd.div_init) begin
      rem_r <= OFF_W'(offset);
    end
    if (cmd.div_step) begin
      quot_r <= div_prod[DIV_SH +: IDX_W];
    end
    if (mem_re) begin
      rd_row_r <= rd_row;
    end
    if (cmd.pick) begin
      idx_r     <= {rd_row_r, pick_bit};
      new_row_r <= row_val | (ROW_W'(1) << pick_bit);
    end
    if (cmd.mul) begin
      prod_r <= 32'(idx_r) * 32'(BLOCK_BYTES);
    end
    if (cmd.ld_out) begin
      out_status_r <= cmd.out_kind;
      out_addr_r   <= res_addr;
      out_index_r  <= res_index;
      out_used_r   <= 6'(used_nxt);
      out_alloc_r  <= alloc_nxt;
      out_free_r   <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      used_cnt_r  <= '0;
      alloc_cnt_r <= '0;
      free_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        row_full_r[r] <= ((r * ROW_W) >= NUM_BLOCKS);
      end
    end else begin
      if (mem_re) begin
        rd_vld_r <= row_vld_r[rd_row];
      end
      if (mem_we) begin
        row_vld_r[wr_row]  <= 1'b1;
        row_full_r[wr_row] <= &wr_data;
      end
      used_cnt_r  <= used_nxt;
      alloc_cnt_r <= alloc_nxt;
      free_cnt_r  <= free_nxt;
      out_valid_r <= cmd.ld_out | (out_valid_r & out_stall);
    end
  end

  assign sts.in_op    = in_opcode;
  assign sts.any_free = any_free;
  assign sts.free_ign = (addr_r == 32'd0) || (offset >= 32'(POOL_BYTES));
  assign sts.blk_used = row_val[fbit];
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_index   = out_index_r;
  assign out_used_count    = out_used_r;
  assign out_alloc_total   = out_alloc_r;
  assign out_free_total    = out_free_r;

`ifndef SYNTHESIS
  a_alloc_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_alloc |-> (used_cnt_r < UC_W'(NUM_BLOCKS)))
    else $error("block allocated while every block is in use");
  a_free_has_user: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_free |-> (used_cnt_r != '0))
    else $error("block released while no block is in use");
  a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_alloc |=> (used_cnt_r == ($past(used_cnt_r) + UC_W'(1))))
    else $error("used count did not follow an allocation");
`endif

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: register port, controller and datapath.
`timescale 1ns / 1ps

// Channel | Handshake         | Payload
// in      | in_valid/in_stall   | in_opcode, in_free_address
// out     | out_valid/out_stall | out_status, out_block_address, out_block_index,
//         |                     | out_used_count, out_alloc_total, out_free_total
// cfg     | psel/penable/pready | paddr, pwrite, pwdata, prdata (pool_base at 0)
//
// An allocation runs from acceptance through a search of the
// row-full flags, a registered read of the used-map row, the bit pick and the address multiply;
// an allocation from a full pool ends after the flag search.
// A free runs through the pool check, a reciprocal multiply that gives the block index,
// and a registered read and update of the used-map row; a free of null or outside the pool
// ends after the pool check.
// Reset is synchronous: all blocks free, counters zero, pool_base 4096, no clearing pass.
// A stalled result stays in the output register and the block holds its work until it drains.

module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [4:0]  out_block_index,
  output logic [5:0]  out_used_count,
  output logic [31:0] out_alloc_total,
  output logic [31:0] out_free_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fbpa_pkg::fbpa_cmd_t cmd;
  fbpa_pkg::fbpa_sts_t sts;
  logic [31:0]         pool_base_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == fbpa_pkg::REG_POOL_BASE);
  assign prdata = (paddr[2] == fbpa_pkg::REG_POOL_BASE) ? pool_base_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= fbpa_pkg::POOL_BASE_RST;
    end else if (cfg_wr) begin
      pool_base_r <= pwdata;
    end
  end

  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpa_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_opcode),
    .in_free_address   (in_free_address),
    .pool_base         (pool_base_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_block_index   (out_block_index),
    .out_used_count    (out_used_count),
    .out_alloc_total   (out_alloc_total),
    .out_free_total    (out_free_total)
  );

endmodule
